/* rtl/core/llws_pkg.sv */
// Shared types and constants for the least-loaded worker select block.
package llws_pkg;

  localparam int MAX_WORKERS  = 64;
  localparam int LOAD_WIDTH   = 48;
  localparam int FIELD_WIDTH  = 32;
  localparam int ADDEND_WIDTH = FIELD_WIDTH + 1;
  localparam int INDEX_WIDTH  = 6;
  localparam int COUNT_WIDTH  = $clog2(MAX_WORKERS + 1);
  localparam int CMDQ_DEPTH   = 2;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH   = 2;
  localparam int RESQ_PTR_W   = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W   = $clog2(RESQ_DEPTH + 1);

  localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

  typedef enum logic [1:0] {
    OP_HEADER     = 2'd0,
    OP_TERM       = 2'd1,
    OP_EMPTY_SCAN = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACC_LOAD = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_KEEP = 2'd2
  } acc_mode_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic                   prefill;
    logic [FIELD_WIDTH-1:0] wait_tokens;
    logic                   busy_req;
    logic [FIELD_WIDTH-1:0] run_tokens;
    logic [FIELD_WIDTH-1:0] kv_wait_tokens;
    logic [FIELD_WIDTH-1:0] req_prompt_tokens;
    logic [FIELD_WIDTH-1:0] req_done_tokens;
    logic                   last_of_worker;
    logic                   last_of_scan;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [INDEX_WIDTH-1:0] worker_index;
    logic [LOAD_WIDTH-1:0]  best_load;
  } out_item_t;

  typedef struct packed {
    acc_mode_t               acc_mode;
    logic [ADDEND_WIDTH-1:0] value;
    logic                    close_worker;
    logic                    close_scan;
    logic                    empty_scan;
  } cmd_t;

endpackage

/* rtl/core/llws_front.sv */
// Front end: classifies an input item and forms its load contribution.
module llws_front (
  input  llws_pkg::in_item_t request,
  output logic               keep,
  output llws_pkg::cmd_t     cmd
);

  logic [llws_pkg::ADDEND_WIDTH-1:0] queued_ext;
  logic [llws_pkg::ADDEND_WIDTH-1:0] prefill_load;
  logic [llws_pkg::ADDEND_WIDTH-1:0] decode_load;
  logic [llws_pkg::ADDEND_WIDTH-1:0] term_load;

  assign queued_ext = {1'b0, request.wait_tokens};

  // Header and term sums never exceed 33 bits, so no saturation is needed here.
  always_comb begin
    prefill_load = queued_ext;
    if (request.busy_req) begin
      prefill_load = queued_ext + {1'b0, request.run_tokens}
                     + llws_pkg::ADDEND_WIDTH'(1);
    end
  end

  assign decode_load = queued_ext + {1'b0, request.kv_wait_tokens};
  assign term_load   = {1'b0, request.req_prompt_tokens} + {1'b0, request.req_done_tokens};

  always_comb begin
    cmd.acc_mode     = llws_pkg::ACC_KEEP;
    cmd.value        = term_load;
    cmd.close_worker = request.last_of_worker;
    cmd.close_scan   = request.last_of_scan;
    cmd.empty_scan   = 1'b0;
    keep             = 1'b1;
    case (request.operation)
      llws_pkg::OP_HEADER: begin
        cmd.acc_mode = llws_pkg::ACC_LOAD;
        cmd.value    = request.prefill ? prefill_load : decode_load;
      end
      llws_pkg::OP_TERM: begin
        cmd.acc_mode = request.prefill ? llws_pkg::ACC_KEEP : llws_pkg::ACC_ADD;
      end
      llws_pkg::OP_EMPTY_SCAN: begin
        cmd.empty_scan   = 1'b1;
        cmd.close_worker = 1'b0;
        cmd.close_scan   = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/llws_cmd_queue.sv */
// Short command queue between the front end and the scan engine.
module llws_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  llws_pkg::cmd_t wr_data,
  input  logic           pop,
  output logic           empty,
  output llws_pkg::cmd_t rd_data
);

  llws_pkg::cmd_t                  slots [llws_pkg::CMDQ_DEPTH];
  logic [llws_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [llws_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [llws_pkg::CMDQ_CNT_W-1:0] count;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == llws_pkg::CMDQ_CNT_W'(llws_pkg::CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == llws_pkg::CMDQ_PTR_W'(llws_pkg::CMDQ_DEPTH - 1)) ? '0
                  : wr_ptr + llws_pkg::CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == llws_pkg::CMDQ_PTR_W'(llws_pkg::CMDQ_DEPTH - 1)) ? '0
                  : rd_ptr + llws_pkg::CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + llws_pkg::CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - llws_pkg::CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/llws_back.sv */
// Scan engine: load accumulator, running minimum, and the result buffer.
module llws_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  llws_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output llws_pkg::out_item_t result
);

  logic [llws_pkg::COUNT_WIDTH-1:0] worker_counter;
  logic [llws_pkg::LOAD_WIDTH-1:0]  load_accumulator;
  logic [llws_pkg::LOAD_WIDTH-1:0]  best_value;
  logic [llws_pkg::INDEX_WIDTH-1:0] best_index;
  logic                             any_worker_seen;

  logic [llws_pkg::COUNT_WIDTH-1:0] worker_counter_next;
  logic [llws_pkg::LOAD_WIDTH-1:0]  load_accumulator_next;
  logic [llws_pkg::LOAD_WIDTH-1:0]  best_value_next;
  logic [llws_pkg::INDEX_WIDTH-1:0] best_index_next;
  logic                             any_worker_seen_next;

  logic [llws_pkg::LOAD_WIDTH:0]    acc_sum;
  logic [llws_pkg::LOAD_WIDTH-1:0]  acc_new;
  logic                             closing;
  logic                             res_push;
  llws_pkg::out_item_t              res_item;

  llws_pkg::out_item_t              res_slots [llws_pkg::RESQ_DEPTH];
  logic [llws_pkg::RESQ_PTR_W-1:0]  res_wr_ptr;
  logic [llws_pkg::RESQ_PTR_W-1:0]  res_rd_ptr;
  logic [llws_pkg::RESQ_CNT_W-1:0]  res_count;
  logic                             res_full;
  logic                             res_pop;

  assign res_full = (res_count == llws_pkg::RESQ_CNT_W'(llws_pkg::RESQ_DEPTH));
  assign empty    = (res_count == '0);
  assign res_pop  = pop && !empty;
  assign result   = res_slots[res_rd_ptr];

  // A command is taken only when the result buffer has room for what it may emit.
  assign cmd_pop  = !cmd_empty && !res_full;

  assign acc_sum = {1'b0, load_accumulator}
                   + (llws_pkg::LOAD_WIDTH + 1)'(cmd.value);

  always_comb begin
    case (cmd.acc_mode)
      llws_pkg::ACC_LOAD: acc_new = llws_pkg::LOAD_WIDTH'(cmd.value);
      llws_pkg::ACC_ADD:  acc_new = acc_sum[llws_pkg::LOAD_WIDTH] ? llws_pkg::LOAD_MAX
                                    : acc_sum[llws_pkg::LOAD_WIDTH-1:0];
      default:            acc_new = load_accumulator;
    endcase
  end

  assign closing = cmd.close_worker || cmd.close_scan;

  always_comb begin
    worker_counter_next   = worker_counter;
    load_accumulator_next = acc_new;
    best_value_next       = best_value;
    best_index_next       = best_index;
    any_worker_seen_next  = any_worker_seen;
    res_push              = 1'b0;
    res_item              = '0;

    if (closing) begin
      load_accumulator_next = '0;
      // Workers past the table size are not compared and the id stops advancing.
      if (worker_counter < llws_pkg::COUNT_WIDTH'(llws_pkg::MAX_WORKERS)) begin
        if (acc_new < best_value) begin
          best_value_next = acc_new;
          best_index_next = worker_counter[llws_pkg::INDEX_WIDTH-1:0];
        end
        any_worker_seen_next = 1'b1;
        worker_counter_next  = worker_counter + llws_pkg::COUNT_WIDTH'(1);
      end
    end

    if (cmd.empty_scan || cmd.close_scan) begin
      res_push = 1'b1;
      if (cmd.close_scan && any_worker_seen_next) begin
        res_item.found        = 1'b1;
        res_item.worker_index = best_index_next;
        res_item.best_load    = best_value_next;
      end
      worker_counter_next   = '0;
      load_accumulator_next = '0;
      best_value_next       = llws_pkg::LOAD_MAX;
      best_index_next       = '0;
      any_worker_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_counter   <= '0;
      load_accumulator <= '0;
      best_value       <= llws_pkg::LOAD_MAX;
      best_index       <= '0;
      any_worker_seen  <= 1'b0;
    end else if (cmd_pop) begin
      worker_counter   <= worker_counter_next;
      load_accumulator <= load_accumulator_next;
      best_value       <= best_value_next;
      best_index       <= best_index_next;
      any_worker_seen  <= any_worker_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && res_push) begin
      res_slots[res_wr_ptr] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (cmd_pop && res_push) begin
        res_wr_ptr <= (res_wr_ptr == llws_pkg::RESQ_PTR_W'(llws_pkg::RESQ_DEPTH - 1)) ? '0
                      : res_wr_ptr + llws_pkg::RESQ_PTR_W'(1);
      end
      if (res_pop) begin
        res_rd_ptr <= (res_rd_ptr == llws_pkg::RESQ_PTR_W'(llws_pkg::RESQ_DEPTH - 1)) ? '0
                      : res_rd_ptr + llws_pkg::RESQ_PTR_W'(1);
      end
      if ((cmd_pop && res_push) && !res_pop) begin
        res_count <= res_count + llws_pkg::RESQ_CNT_W'(1);
      end else if (res_pop && !(cmd_pop && res_push)) begin
        res_count <= res_count - llws_pkg::RESQ_CNT_W'(1);
      end
    end
  end

  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !res_full)
    else $error("result buffer written while full");

  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && (cmd.empty_scan || cmd.close_scan) |=>
      worker_counter == '0 && !any_worker_seen && load_accumulator == '0
      && best_value == llws_pkg::LOAD_MAX)
    else $error("scan state not cleared after a result");

  a_best_index_valid: assert property (@(posedge clk) disable iff (rst)
    any_worker_seen |->
      (llws_pkg::COUNT_WIDTH'(best_index) < worker_counter))
    else $error("best index not among closed workers");

  a_unseen_is_clean: assert property (@(posedge clk) disable iff (rst)
    !any_worker_seen |-> best_value == llws_pkg::LOAD_MAX && worker_counter == '0)
    else $error("best value moved without a closed worker");

endmodule

/* rtl/core/least_loaded_worker_select_core.sv */
// Least-loaded worker select: top level joining front end, queue and scan engine.
// Throughput: one item per cycle while neither the command queue nor the result buffer is full.
// A scan-closing item is registered in the command queue, then its result in the result buffer.
// The two-entry command queue and two-entry result buffer set the stall slack.
// Reset (rst, synchronous) empties both queues and returns the scan state to
// worker 0, zero load, an all-ones best load and no worker seen.
module least_loaded_worker_select_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  llws_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output llws_pkg::out_item_t result
);

  llws_pkg::cmd_t front_cmd;
  llws_pkg::cmd_t queue_cmd;
  logic           front_keep;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign full = q_full;

  llws_front u_front (
    .request (request),
    .keep    (front_keep),
    .cmd     (front_cmd)
  );

  // Items with the unused operation code are accepted and dropped here.
  llws_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push && front_keep),
    .full    (q_full),
    .wr_data (front_cmd),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (queue_cmd)
  );

  llws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd       (queue_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the least-loaded worker select core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 500;

  logic                clk = 1'b0;
  logic                rst;
  logic                push;
  logic                full;
  llws_pkg::in_item_t  request;
  logic                empty;
  logic                pop;
  llws_pkg::out_item_t result;

  least_loaded_worker_select_core u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .request(request),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  llws_pkg::in_item_t  pending_items[$];
  llws_pkg::out_item_t expected_picks[$];
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  errors = 0;
  int                  cycle_count = 0;

  // Tracked scan state.
  int                               trk_worker = 0;
  logic [llws_pkg::LOAD_WIDTH-1:0]  trk_acc = '0;
  logic [llws_pkg::LOAD_WIDTH-1:0]  trk_best = llws_pkg::LOAD_MAX;
  logic [llws_pkg::INDEX_WIDTH-1:0] trk_best_id = '0;
  logic                             trk_seen = 1'b0;

  always #4 clk = ~clk;

  function automatic logic [llws_pkg::LOAD_WIDTH-1:0] sat_sum(
      logic [llws_pkg::LOAD_WIDTH-1:0] a, logic [llws_pkg::LOAD_WIDTH-1:0] b);
    logic [llws_pkg::LOAD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[llws_pkg::LOAD_WIDTH] ? llws_pkg::LOAD_MAX : s[llws_pkg::LOAD_WIDTH-1:0];
  endfunction

  task automatic clear_tracker();
    trk_worker  = 0;
    trk_acc     = '0;
    trk_best    = llws_pkg::LOAD_MAX;
    trk_best_id = '0;
    trk_seen    = 1'b0;
  endtask

  // Updates the tracked scan with one accepted item and queues the pick it yields.
  task automatic track_item(input llws_pkg::in_item_t it);
    llws_pkg::out_item_t             pick;
    logic [llws_pkg::LOAD_WIDTH-1:0] v;
    pick = '0;
    if (it.operation == llws_pkg::OP_EMPTY_SCAN) begin
      clear_tracker();
      expected_picks.push_back(pick);
    end else if (it.operation != llws_pkg::OP_UNUSED) begin
      if (it.operation == llws_pkg::OP_HEADER) begin
        v = llws_pkg::LOAD_WIDTH'(it.wait_tokens);
        if (it.prefill) begin
          if (it.busy_req)
            v = sat_sum(v, llws_pkg::LOAD_WIDTH'(it.run_tokens)
                           + llws_pkg::LOAD_WIDTH'(1));
        end else begin
          v = sat_sum(v, llws_pkg::LOAD_WIDTH'(it.kv_wait_tokens));
        end
        trk_acc = v;
      end else if (!it.prefill) begin
        trk_acc = sat_sum(trk_acc, sat_sum(llws_pkg::LOAD_WIDTH'(it.req_prompt_tokens),
                                           llws_pkg::LOAD_WIDTH'(it.req_done_tokens)));
      end
      if (it.last_of_worker || it.last_of_scan) begin
        // Workers past the id range are dropped without comparison.
        if (trk_worker < llws_pkg::MAX_WORKERS) begin
          if (trk_acc < trk_best) begin
            trk_best    = trk_acc;
            trk_best_id = llws_pkg::INDEX_WIDTH'(trk_worker);
          end
          trk_seen = 1'b1;
          trk_worker++;
        end
        trk_acc = '0;
      end
      if (it.last_of_scan) begin
        if (trk_seen) begin
          pick.found        = 1'b1;
          pick.worker_index = trk_best_id;
          pick.best_load    = trk_best;
        end
        expected_picks.push_back(pick);
        clear_tracker();
      end
    end
  endtask

  // Mixes zero, all ones, small values (to force ties) and full random words.
  function automatic logic [llws_pkg::FIELD_WIDTH-1:0] rand_tokens();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return llws_pkg::FIELD_WIDTH'($urandom_range(0, 15));
      default: return llws_pkg::FIELD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic llws_pkg::in_item_t mk_item(llws_pkg::op_t op, logic pre, logic lw,
                                                 logic ls);
    llws_pkg::in_item_t it;
    it.operation         = op;
    it.prefill           = pre;
    it.wait_tokens       = rand_tokens();
    it.busy_req          = 1'($urandom_range(0, 1));
    it.run_tokens        = rand_tokens();
    it.kv_wait_tokens    = rand_tokens();
    it.req_prompt_tokens = rand_tokens();
    it.req_done_tokens   = rand_tokens();
    it.last_of_worker    = lw;
    it.last_of_scan      = ls;
    return it;
  endfunction

  function automatic llws_pkg::in_item_t mk_header(logic pre, logic busy,
                                                   logic [llws_pkg::FIELD_WIDTH-1:0] q,
                                                   logic [llws_pkg::FIELD_WIDTH-1:0] bt,
                                                   logic [llws_pkg::FIELD_WIDTH-1:0] kv,
                                                   logic lw, logic ls);
    llws_pkg::in_item_t it;
    it = mk_item(llws_pkg::OP_HEADER, pre, lw, ls);
    it.busy_req       = busy;
    it.wait_tokens    = q;
    it.run_tokens     = bt;
    it.kv_wait_tokens = kv;
    return it;
  endfunction

  function automatic llws_pkg::in_item_t mk_term(logic pre,
                                                 logic [llws_pkg::FIELD_WIDTH-1:0] pl,
                                                 logic [llws_pkg::FIELD_WIDTH-1:0] od,
                                                 logic lw, logic ls);
    llws_pkg::in_item_t it;
    it = mk_item(llws_pkg::OP_TERM, pre, lw, ls);
    it.req_prompt_tokens = pl;
    it.req_done_tokens   = od;
    return it;
  endfunction

  // One well-formed scan with random content, plus occasional open cases.
  task automatic add_scan(output int n_items);
    int   n_workers;
    int   n_terms;
    logic pre;
    logic ls;
    n_items   = 0;
    pre       = 1'($urandom_range(0, 1));
    n_workers = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) begin
      pending_items.push_back(mk_item(llws_pkg::OP_TERM, pre, 1'b0, 1'b0));
      n_items++;
    end
    for (int w = 0; w < n_workers; w++) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(mk_item(llws_pkg::OP_HEADER, pre, 1'b0, 1'b0));
        n_items++;
      end
      if (pre)
        n_terms = ($urandom_range(0, 9) == 0) ? 1 : 0;
      else
        n_terms = $urandom_range(0, 3);
      for (int t = 0; t <= n_terms; t++) begin
        ls = (w == n_workers - 1) && (t == n_terms);
        pending_items.push_back(mk_item((t == 0) ? llws_pkg::OP_HEADER : llws_pkg::OP_TERM,
                                        pre,
                                        (t == n_terms) &&
                                        !(ls && $urandom_range(0, 7) == 0), ls));
        n_items++;
      end
    end
  endtask

  task automatic add_random(input int target);
    int count;
    int n;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 99) < 85) begin
        add_scan(n);
        count += n;
      end else begin
        pending_items.push_back(mk_item(llws_pkg::op_t'($urandom_range(0, 3)),
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
        if (pending_items[$].operation != llws_pkg::OP_UNUSED)
          count++;
      end
    end
  endtask

  task automatic add_directed();
    pending_items.push_back(mk_item(llws_pkg::OP_EMPTY_SCAN, 1'b1, 1'b1, 1'b1));
    // Prefill: idle worker with zero load wins over a busy one.
    pending_items.push_back(mk_header(1'b1, 1'b1, '1, '1, '0, 1'b1, 1'b0));
    pending_items.push_back(mk_header(1'b1, 1'b0, '0, '1, '1, 1'b1, 1'b0));
    pending_items.push_back(mk_header(1'b1, 1'b1, '0, '0, '1, 1'b1, 1'b1));
    // Decode: tie between worker 0 and worker 1 goes to worker 0.
    pending_items.push_back(mk_header(1'b0, 1'b0, 32'd5, '0, 32'd5, 1'b1, 1'b0));
    pending_items.push_back(mk_header(1'b0, 1'b1, 32'd3, '1, 32'd2, 1'b0, 1'b0));
    pending_items.push_back(mk_term(1'b0, 32'd3, 32'd2, 1'b1, 1'b0));
    pending_items.push_back(mk_header(1'b0, 1'b0, '1, '0, '1, 1'b0, 1'b0));
    pending_items.push_back(mk_term(1'b0, '1, '1, 1'b1, 1'b1));
    // Term with no header, then the scan closes on an item whose last-of-worker flag is clear.
    pending_items.push_back(mk_term(1'b0, 32'd7, 32'd1, 1'b0, 1'b0));
    pending_items.push_back(mk_item(llws_pkg::OP_UNUSED, 1'b1, 1'b1, 1'b1));
    pending_items.push_back(mk_term(1'b0, 32'd2, 32'd0, 1'b0, 1'b1));
    // Header while a worker is open, and a term on a prefill item.
    pending_items.push_back(mk_header(1'b0, 1'b0, '1, '0, '1, 1'b0, 1'b0));
    pending_items.push_back(mk_header(1'b1, 1'b0, 32'd9, '0, '0, 1'b0, 1'b0));
    pending_items.push_back(mk_term(1'b1, '1, '1, 1'b1, 1'b0));
    pending_items.push_back(mk_header(1'b1, 1'b1, 32'd4, 32'd4, '0, 1'b1, 1'b1));
    // Empty scan abandons a partial scan.
    pending_items.push_back(mk_header(1'b0, 1'b0, 32'd1, '0, 32'd1, 1'b1, 1'b0));
    pending_items.push_back(mk_item(llws_pkg::OP_EMPTY_SCAN, 1'b0, 1'b0, 1'b0));
    // Falling loads past the id range: the last compared worker wins.
    for (int w = 0; w < llws_pkg::MAX_WORKERS + 2; w++)
      pending_items.push_back(mk_header(1'b0, 1'b0, 32'(1000 - w), '0, '0, 1'b1,
                                        w == llws_pkg::MAX_WORKERS + 1));
  endtask

  // Driver: presents queued items, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      request <= '0;
    end else begin
      if (push && !full)
        track_item(request);
      if (!push || !full) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push    <= 1'b1;
          request <= pending_items.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results and checks them against the oldest expected pick.
  always @(posedge clk) begin
    llws_pkg::out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_picks.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: found %0b index %0d load %0h",
                   $time, result.found, result.worker_index, result.best_load);
        end else begin
          want = expected_picks.pop_front();
          if (result.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0b actual %0b", $time, want.found,
                     result.found);
          end
          if (result.worker_index !== want.worker_index) begin
            errors++;
            $display("%0t: worker_index expected %0d actual %0d", $time,
                     want.worker_index, result.worker_index);
          end
          if (result.best_load !== want.best_load) begin
            errors++;
            $display("%0t: best_load expected %0h actual %0h", $time,
                     want.best_load, result.best_load);
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 76, 0, 15};
    recv_pct = '{0, 0, 76, 15};
    rst      = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0)
        add_directed();
      add_random(RANDOM_ITEMS);
      @(posedge clk);
      while (pending_items.size() != 0 || push || expected_picks.size() != 0)
        @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/llws_pkg.sv
rtl/core/llws_front.sv
rtl/core/llws_cmd_queue.sv
rtl/core/llws_back.sv
rtl/core/least_loaded_worker_select_core.sv
sim/tb_top.sv
